[sv/tsr_pkg.sv]
// Shared types and constants for the three-subset rank/unrank block.
package tsr_pkg;

	// Fixed field widths
	localparam int IDX_W = 28;
	localparam int VAL_W = 10;
	localparam int CMD_W = 2;
	localparam int STAT_W = 2;

	// Shared multiplier and its helpers
	localparam int MUL_W = 32;
	localparam int PROD_W = 2 * MUL_W;
	// Compare target: six times the largest index
	localparam int TGT_W = 31;
	// Exact division by three uses the inverse of 3 modulo 2^INV_W
	localparam int INV_W = 30;
	localparam logic [INV_W-1:0] INV3 = 30'h2AAA_AAAB;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_INDEX = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SUBSET = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PART = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ORDER = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] index_in;
		logic [VAL_W-1:0] value_hi;
		logic [VAL_W-1:0] value_mid;
		logic [VAL_W-1:0] value_lo;
	} tsr_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] index_out;
		logic [VAL_W-1:0] set_hi;
		logic [VAL_W-1:0] set_mid;
		logic [VAL_W-1:0] set_lo;
		logic [VAL_W-1:0] part_hi;
		logic [VAL_W-1:0] part_mid;
		logic [VAL_W-1:0] part_lo;
		logic [STAT_W-1:0] status;
	} tsr_result_t;

endpackage

[sv/tsr_mul.sv]
// Shared registered multiplier used by the rank/unrank sequencer.
module tsr_mul
	import tsr_pkg::*;
(
	input  logic              clk,
	input  logic              en,
	input  logic [MUL_W-1:0]  a,
	input  logic [MUL_W-1:0]  b,
	output logic [PROD_W-1:0] prod
);

	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] prod_d;

	// full-width product of the two operands
	assign prod_d = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= prod_d;
		end
	end

	assign prod = prod_q;

endmodule

[sv/three_subset_rank_unrank.sv]
// Top level: rank/unrank of 3-subsets in the combinatorial number system.
// Converts one beat between index, 3-subset and 3-part partition forms.
// A beat is taken when start is high and busy is low; busy then stays high until
// the result has been produced, and each result appears for exactly one cycle
// with done high, so the receiver must take it in that cycle. Unranking (cmd 0)
// runs two binary searches on a single shared multiplier: each cubic search
// step passes through ST_SRCH, ST_MUL2 and ST_CMP, each quadratic step through
// ST_SRCH and ST_CMP, and each search takes ELEMENT_BITS - 1 or ELEMENT_BITS
// steps depending on the path. Ranking (cmd 1 and 2) steps through ST_BIN1,
// ST_BIN2, ST_BIN3, ST_ACC3, ST_BIN1 and ST_ACC2. A beat is only taken while
// busy is low, so no new beat enters before the last is converted. Beats
// rejected on order or range, and the unused command, give their result the
// cycle after and leave busy low.
module three_subset_rank_unrank
	import tsr_pkg::*;
#(
	parameter int ELEMENT_BITS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  tsr_item_t   item,
	output logic        busy,
	output logic        done,
	output tsr_result_t result
);

	localparam int EB = ELEMENT_BITS;
	// subset register width: room for a partition part plus two
	localparam int SW = (ELEMENT_BITS > VAL_W + 1) ? ELEMENT_BITS : VAL_W + 1;
	localparam logic [63:0] ELEM_LIMIT = 64'd1 << ELEMENT_BITS;
	localparam logic [63:0] IDX_LIMIT =
		(ELEM_LIMIT * (ELEM_LIMIT - 64'd1) * (ELEM_LIMIT - 64'd2)) / 64'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SRCH,
		ST_MUL2,
		ST_CMP,
		ST_BIN1,
		ST_BIN2,
		ST_BIN3,
		ST_ACC3,
		ST_ACC2
	} state_t;

	state_t            state_q;
	logic [EB-1:0]     lo_q;
	logic [EB-1:0]     hi_q;
	logic [EB-1:0]     mid_q;
	logic              big_q;
	logic              dig3_q;
	logic              rank_q;
	logic [SW-1:0]     s0_q;
	logic [SW-1:0]     s1_q;
	logic [SW-1:0]     s2_q;
	logic [IDX_W-1:0]  acc_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TGT_W-1:0]  tgt_q;
	logic              done_q;
	tsr_result_t       result_q;

	logic [EB:0]       span;
	logic [EB-1:0]     mid;
	logic [EB-1:0]     mid_m1;
	logic [EB-1:0]     midq_m1;
	logic [EB-1:0]     midq_m2;
	logic [SW-1:0]     mul_c;
	logic [SW-1:0]     mul_c_m1;
	logic [SW-1:0]     s0_m2;
	logic [SW-1:0]     s1_m1;
	logic [SW-1:0]     s2_fin;
	logic [MUL_W-1:0]  mul_a;
	logic [MUL_W-1:0]  mul_b;
	logic              mul_en;
	logic [PROD_W-1:0] prod;
	logic [IDX_W-1:0]  addend;
	logic [IDX_W-1:0]  acc_nxt;
	logic              le;
	logic              ord_sub;
	logic              ord_part;
	logic [VAL_W:0]    a_p2;
	logic [VAL_W:0]    b_p1;
	logic [STAT_W-1:0] start_stat;
	logic [TGT_W-1:0]  idx6;

	// binary search midpoint: lo + ceil((hi - lo) / 2)
	assign span = {1'b0, hi_q} - {1'b0, lo_q} + (EB+1)'(1);
	assign mid = lo_q + span[EB:1];
	assign mid_m1 = mid - EB'(1);
	assign midq_m1 = mid_q - EB'(1);
	assign midq_m2 = mid_q - EB'(2);

	// operand of the exact binomial steps
	assign mul_c = dig3_q ? s0_q : s1_q;
	assign mul_c_m1 = mul_c - SW'(1);
	assign s0_m2 = s0_q - SW'(2);
	assign s1_m1 = s1_q - SW'(1);

	// multiplier operand select per sequencer step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SRCH: begin
				mul_a = MUL_W'(mid);
				mul_b = MUL_W'(mid_m1);
			end
			ST_MUL2: begin
				mul_a = prod[MUL_W-1:0];
				mul_b = MUL_W'(midq_m2);
			end
			ST_BIN1: begin
				mul_a = MUL_W'(mul_c);
				mul_b = MUL_W'(mul_c_m1);
			end
			ST_BIN2: begin
				mul_a = prod[MUL_W-1:0];
				mul_b = MUL_W'(s0_m2);
			end
			ST_BIN3: begin
				// c(c-1)(c-2)/2 times the inverse of 3 gives C(c,3) exactly
				mul_a = MUL_W'(prod[INV_W:1]);
				mul_b = MUL_W'(INV3);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_en = (state_q != ST_IDLE);

	tsr_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// index accumulator: C(c,3) after the cubic step, C(c,2) after the quadratic
	assign addend = (state_q == ST_ACC3) ? prod[IDX_W-1:0] : prod[IDX_W:1];
	assign acc_nxt = rank_q ? (acc_q + addend) : (acc_q - addend);

	// search compare against the scaled remainder
	assign le = !big_q && (prod <= PROD_W'(tgt_q));

	assign s2_fin = rank_q ? s2_q : acc_nxt[SW-1:0];

	// order and range checks on the incoming beat
	assign ord_sub = (item.value_hi > item.value_mid) && (item.value_mid > item.value_lo);
	assign ord_part = (item.value_hi >= item.value_mid) && (item.value_mid >= item.value_lo);
	assign a_p2 = {1'b0, item.value_hi} + (VAL_W+1)'(2);
	assign b_p1 = {1'b0, item.value_mid} + (VAL_W+1)'(1);
	assign idx6 = TGT_W'({item.index_in, 2'b00}) + TGT_W'({item.index_in, 1'b0});

	always_comb begin
		case (item.cmd)
			CMD_INDEX: begin
				start_stat = (64'(item.index_in) >= IDX_LIMIT) ? STAT_RANGE : STAT_OK;
			end
			CMD_SUBSET: begin
				if (!ord_sub) start_stat = STAT_ORDER;
				else if (64'(item.value_hi) >= ELEM_LIMIT) start_stat = STAT_RANGE;
				else start_stat = STAT_OK;
			end
			CMD_PART: begin
				if (!ord_part) start_stat = STAT_ORDER;
				else if (64'(a_p2) >= ELEM_LIMIT) start_stat = STAT_RANGE;
				else start_stat = STAT_OK;
			end
			default: begin
				start_stat = STAT_RANGE;
			end
		endcase
	end

	// sequencer, datapath registers and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			// strobe on a rejected beat at rest or on the last conversion step
			done_q <= (state_q == ST_ACC2) ||
				((state_q == ST_IDLE) && start && (start_stat != STAT_OK));
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (start_stat != STAT_OK) begin
							result_q.index_out <= '0;
							result_q.set_hi <= '0;
							result_q.set_mid <= '0;
							result_q.set_lo <= '0;
							result_q.part_hi <= '0;
							result_q.part_mid <= '0;
							result_q.part_lo <= '0;
							result_q.status <= start_stat;
						end else if (item.cmd == CMD_INDEX) begin
							idx_q <= item.index_in;
							acc_q <= item.index_in;
							tgt_q <= idx6;
							lo_q <= EB'(2);
							hi_q <= '1;
							dig3_q <= 1'b1;
							rank_q <= 1'b0;
							state_q <= ST_SRCH;
						end else begin
							if (item.cmd == CMD_SUBSET) begin
								s0_q <= SW'(item.value_hi);
								s1_q <= SW'(item.value_mid);
							end else begin
								s0_q <= SW'(a_p2);
								s1_q <= SW'(b_p1);
							end
							s2_q <= SW'(item.value_lo);
							acc_q <= IDX_W'(item.value_lo);
							dig3_q <= 1'b1;
							rank_q <= 1'b1;
							state_q <= ST_BIN1;
						end
					end
				end
				ST_SRCH: begin
					big_q <= 1'b0;
					if (lo_q == hi_q) begin
						if (dig3_q) s0_q <= SW'(lo_q);
						else s1_q <= SW'(lo_q);
						state_q <= ST_BIN1;
					end else begin
						mid_q <= mid;
						state_q <= dig3_q ? ST_MUL2 : ST_CMP;
					end
				end
				ST_MUL2: begin
					// c(c-1) beyond 32 bits means C(c,3) is far above any index
					big_q <= (prod[PROD_W-1:MUL_W] != '0);
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (le) lo_q <= mid_q;
					else hi_q <= midq_m1;
					state_q <= ST_SRCH;
				end
				ST_BIN1: begin
					state_q <= dig3_q ? ST_BIN2 : ST_ACC2;
				end
				ST_BIN2: begin
					state_q <= ST_BIN3;
				end
				ST_BIN3: begin
					state_q <= ST_ACC3;
				end
				ST_ACC3: begin
					acc_q <= acc_nxt;
					dig3_q <= 1'b0;
					if (rank_q) begin
						state_q <= ST_BIN1;
					end else begin
						lo_q <= EB'(1);
						hi_q <= '1;
						tgt_q <= TGT_W'({acc_nxt, 1'b0});
						state_q <= ST_SRCH;
					end
				end
				ST_ACC2: begin
					result_q.index_out <= rank_q ? acc_nxt : idx_q;
					result_q.set_hi <= s0_q[VAL_W-1:0];
					result_q.set_mid <= s1_q[VAL_W-1:0];
					result_q.set_lo <= s2_fin[VAL_W-1:0];
					result_q.part_hi <= s0_m2[VAL_W-1:0];
					result_q.part_mid <= s1_m1[VAL_W-1:0];
					result_q.part_lo <= s2_fin[VAL_W-1:0];
					result_q.status <= STAT_OK;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	// a result only appears once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while sequencer busy");

	// rejected beats carry all-zero forms
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STAT_OK) |->
		(result.index_out == '0 && result.set_hi == '0 && result.part_hi == '0))
		else $error("nonzero fields on rejected beat");

	// search window never inverts
	a_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH) |-> (lo_q <= hi_q))
		else $error("search window inverted");

	// unused command is answered in the next cycle with a range status
	a_unused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.cmd == CMD_UNUSED) |=>
		(done && result.status == STAT_RANGE))
		else $error("unused command not rejected");

	// every busy period ends with a result
	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

[verif/three_subset_rank_unrank_tb.sv]
// Self-checking testbench for the three-subset rank/unrank block.
module three_subset_rank_unrank_tb;
	import tsr_pkg::*;

	localparam int ELEMENT_BITS = 10;
	localparam longint ELEM_LIMIT = longint'(1) << ELEMENT_BITS;
	localparam longint INDEX_LIMIT = ELEM_LIMIT * (ELEM_LIMIT - 1) * (ELEM_LIMIT - 2) / 6;
	localparam int RANDOM_BEATS = 800;
	// Wait after the last expected result before the summary
	localparam int DRAIN_CYCLES = 5 * ELEMENT_BITS + 20;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct {
		tsr_item_t beat;
		bit known;
		tsr_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic start;
	tsr_item_t item;
	logic busy;
	logic done;
	tsr_result_t result;

	tsr_result_t pending_results[$];
	stim_row_t directed_rows[$];
	int errors = 0;
	int results_seen = 0;
	int cycles = 0;
	int beats_by_cmd[4] = '{0, 0, 0, 0};
	int results_by_status[4] = '{0, 0, 0, 0};
	bit burst_mode = 0;

	three_subset_rank_unrank #(.ELEMENT_BITS(ELEMENT_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Binomial coefficient C(c, j) for j = 1..3
	function automatic longint choose(longint c, int j);
		if (j == 1)
			return c;
		if (j == 2)
			return (c < 2) ? 0 : c * (c - 1) / 2;
		return (c < 3) ? 0 : c * (c - 1) * (c - 2) / 6;
	endfunction

	// Largest c in [j-1, ELEM_LIMIT-1] with C(c, j) <= n
	function automatic longint largest_digit(longint n, int j);
		longint lo;
		longint hi;
		longint mid;
		lo = j - 1;
		hi = ELEM_LIMIT - 1;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (choose(mid, j) <= n)
				lo = mid;
			else
				hi = mid - 1;
		end
		return lo;
	endfunction

	// Expected result of one beat: all three forms plus status
	function automatic tsr_result_t convert_triple(tsr_item_t beat);
		tsr_result_t res;
		longint a, b, c, s0, s1, s2, rank, rem;
		logic [STAT_W-1:0] st;
		a = beat.value_hi;
		b = beat.value_mid;
		c = beat.value_lo;
		s0 = 0;
		s1 = 0;
		s2 = 0;
		rank = 0;
		st = STAT_OK;
		case (beat.cmd)
			CMD_INDEX: begin
				if (longint'(beat.index_in) >= INDEX_LIMIT) begin
					st = STAT_RANGE;
				end else begin
					rem = beat.index_in;
					s0 = largest_digit(rem, 3);
					rem -= choose(s0, 3);
					s1 = largest_digit(rem, 2);
					rem -= choose(s1, 2);
					s2 = rem;
					rank = beat.index_in;
				end
			end
			CMD_SUBSET: begin
				if (!(a > b && b > c))
					st = STAT_ORDER;
				else if (a >= ELEM_LIMIT)
					st = STAT_RANGE;
				else begin
					s0 = a;
					s1 = b;
					s2 = c;
				end
			end
			CMD_PART: begin
				if (!(a >= b && b >= c))
					st = STAT_ORDER;
				else if (a + 2 >= ELEM_LIMIT)
					st = STAT_RANGE;
				else begin
					s0 = a + 2;
					s1 = b + 1;
					s2 = c;
				end
			end
			default: st = STAT_RANGE;
		endcase
		if (st == STAT_OK && beat.cmd != CMD_INDEX)
			rank = choose(s0, 3) + choose(s1, 2) + s2;
		res = '0;
		res.status = st;
		if (st == STAT_OK) begin
			res.index_out = rank[IDX_W-1:0];
			res.set_hi = s0[VAL_W-1:0];
			res.set_mid = s1[VAL_W-1:0];
			res.set_lo = s2[VAL_W-1:0];
			res.part_hi = VAL_W'(s0 - 2);
			res.part_mid = VAL_W'(s1 - 1);
			res.part_lo = s2[VAL_W-1:0];
		end
		return res;
	endfunction

	function automatic tsr_item_t mk_beat(logic [CMD_W-1:0] cmd, longint idx,
			int hi, int mid, int lo);
		tsr_item_t beat;
		beat.cmd = cmd;
		beat.index_in = idx[IDX_W-1:0];
		beat.value_hi = VAL_W'(hi);
		beat.value_mid = VAL_W'(mid);
		beat.value_lo = VAL_W'(lo);
		return beat;
	endfunction

	function automatic tsr_result_t mk_res(longint idx, int sh, int sm, int sl,
			int ph, int pm, int pl, logic [STAT_W-1:0] st);
		tsr_result_t res;
		res.index_out = idx[IDX_W-1:0];
		res.set_hi = VAL_W'(sh);
		res.set_mid = VAL_W'(sm);
		res.set_lo = VAL_W'(sl);
		res.part_hi = VAL_W'(ph);
		res.part_mid = VAL_W'(pm);
		res.part_lo = VAL_W'(pl);
		res.status = st;
		return res;
	endfunction

	function automatic void add_row(tsr_item_t beat, bit known, tsr_result_t want);
		stim_row_t row;
		row.beat = beat;
		row.known = known;
		row.want = want;
		directed_rows.insert(directed_rows.size(), row);
	endfunction

	// Random beat: mostly well-formed triples and valid indexes, some noise
	function automatic tsr_item_t random_beat();
		tsr_item_t beat;
		int pick;
		int hi, mid, lo;
		longint idx;
		beat = mk_beat(CMD_INDEX, 0, 0, 0, 0);
		beat.index_in = IDX_W'($urandom);
		beat.value_hi = VAL_W'($urandom);
		beat.value_mid = VAL_W'($urandom);
		beat.value_lo = VAL_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			beat.cmd = CMD_INDEX;
			case ($urandom_range(0, 9))
				0: idx = $urandom_range(0, 200);
				1: idx = INDEX_LIMIT - 1 - $urandom_range(0, 2000);
				2: idx = INDEX_LIMIT + $urandom_range(0, 32'h7fff_ffff)
					% ((longint'(1) << IDX_W) - INDEX_LIMIT);
				default: idx = $urandom_range(0, 32'(INDEX_LIMIT - 1));
			endcase
			beat.index_in = idx[IDX_W-1:0];
		end else if (pick < 65) begin
			beat.cmd = CMD_SUBSET;
			if ($urandom_range(0, 9) < 8) begin
				hi = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 12)
					: $urandom_range(2, 1023);
				mid = $urandom_range(1, hi - 1);
				lo = $urandom_range(0, mid - 1);
				beat.value_hi = VAL_W'(hi);
				beat.value_mid = VAL_W'(mid);
				beat.value_lo = VAL_W'(lo);
			end
		end else if (pick < 90) begin
			beat.cmd = CMD_PART;
			if ($urandom_range(0, 9) < 8) begin
				hi = ($urandom_range(0, 7) == 0) ? $urandom_range(1022, 1023)
					: $urandom_range(0, 1021);
				mid = $urandom_range(0, hi);
				lo = $urandom_range(0, mid);
				beat.value_hi = VAL_W'(hi);
				beat.value_mid = VAL_W'(mid);
				beat.value_lo = VAL_W'(lo);
			end
		end else if (pick < 95) begin
			beat.cmd = CMD_UNUSED;
		end else begin
			beat.cmd = CMD_W'($urandom);
		end
		return beat;
	endfunction

	// Present one beat and hold it until the block takes it
	task automatic send_beat(tsr_item_t beat, tsr_result_t want);
		int gap;
		gap = 0;
		if (!burst_mode) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: gap = 0;
				6, 7, 8: gap = $urandom_range(1, 3);
				default: gap = $urandom_range(10, 40);
			endcase
		end
		if (gap > 0) begin
			start = 0;
			repeat (gap) @(negedge clk);
		end
		item = beat;
		start = 1;
		do
			@(posedge clk);
		while (busy);
		pending_results.insert(pending_results.size(), want);
		beats_by_cmd[beat.cmd]++;
		@(negedge clk);
	endtask

	function automatic void check_field(string name, longint want, longint got,
			bit unknown);
		if (unknown || want != got) begin
			$display("%0t: mismatch on %s: expected %0d, got %0d%s", $time, name,
				want, got, unknown ? " (X/Z)" : "");
			errors++;
		end
	endfunction

	// Result checker: one beat per done cycle against the oldest expectation
	always @(posedge clk) begin
		tsr_result_t want;
		if (arst_n && done === 1'b1) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat, index_out %0d status %0d",
					$time, result.index_out, result.status);
				errors++;
			end else begin
				want = pending_results.pop_front();
				results_by_status[want.status]++;
				check_field("index_out", want.index_out, result.index_out,
					$isunknown(result.index_out));
				check_field("set_hi", want.set_hi, result.set_hi,
					$isunknown(result.set_hi));
				check_field("set_mid", want.set_mid, result.set_mid,
					$isunknown(result.set_mid));
				check_field("set_lo", want.set_lo, result.set_lo,
					$isunknown(result.set_lo));
				check_field("part_hi", want.part_hi, result.part_hi,
					$isunknown(result.part_hi));
				check_field("part_mid", want.part_mid, result.part_mid,
					$isunknown(result.part_mid));
				check_field("part_lo", want.part_lo, result.part_lo,
					$isunknown(result.part_lo));
				check_field("status", want.status, result.status,
					$isunknown(result.status));
			end
		end else if (arst_n && done !== 1'b0) begin
			$display("%0t: done is unknown", $time);
			errors++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time,
				pending_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		tsr_item_t beat;
		tsr_result_t ok_zero;
		tsr_result_t ok_top;
		tsr_result_t order_err;
		tsr_result_t range_err;
		arst_n = 0;
		start = 0;
		item = '0;
		ok_zero = mk_res(0, 2, 1, 0, 0, 0, 0, STAT_OK);
		ok_top = mk_res(INDEX_LIMIT - 1, 1023, 1022, 1021, 1021, 1021, 1021, STAT_OK);
		order_err = mk_res(0, 0, 0, 0, 0, 0, 0, STAT_ORDER);
		range_err = mk_res(0, 0, 0, 0, 0, 0, 0, STAT_RANGE);

		// Directed table: extremes, every command, each error path
		add_row(mk_beat(CMD_INDEX, 0, 0, 0, 0), 1, ok_zero);
		add_row(mk_beat(CMD_INDEX, INDEX_LIMIT - 1, 0, 0, 0), 1, ok_top);
		add_row(mk_beat(CMD_INDEX, INDEX_LIMIT, 0, 0, 0), 1, range_err);
		add_row(mk_beat(CMD_INDEX, (1 << IDX_W) - 1, 1023, 1023, 1023), 1, range_err);
		add_row(mk_beat(CMD_INDEX, 1, 1023, 512, 7), 0, ok_zero);
		add_row(mk_beat(CMD_INDEX, INDEX_LIMIT - 2, 0, 0, 0), 0, ok_zero);
		add_row(mk_beat(CMD_INDEX, 12345678, 0, 0, 0), 0, ok_zero);
		add_row(mk_beat(CMD_SUBSET, 0, 1023, 1022, 1021), 1, ok_top);
		add_row(mk_beat(CMD_SUBSET, 0, 2, 1, 0), 1, ok_zero);
		add_row(mk_beat(CMD_SUBSET, 0, 5, 5, 3), 1, order_err);
		add_row(mk_beat(CMD_SUBSET, 0, 3, 4, 1), 1, order_err);
		add_row(mk_beat(CMD_SUBSET, 0, 0, 0, 0), 1, order_err);
		add_row(mk_beat(CMD_SUBSET, 0, 9, 3, 3), 1, order_err);
		add_row(mk_beat(CMD_SUBSET, (1 << IDX_W) - 1, 10, 5, 2), 0, ok_zero);
		add_row(mk_beat(CMD_SUBSET, 0, 1023, 1, 0), 0, ok_zero);
		add_row(mk_beat(CMD_PART, 0, 0, 0, 0), 1, ok_zero);
		add_row(mk_beat(CMD_PART, 0, 1021, 1021, 1021), 1, ok_top);
		add_row(mk_beat(CMD_PART, 0, 1022, 0, 0), 1, range_err);
		add_row(mk_beat(CMD_PART, 0, 1023, 1023, 1023), 1, range_err);
		add_row(mk_beat(CMD_PART, 0, 1, 2, 0), 1, order_err);
		// misordered and out of range at once: order wins
		add_row(mk_beat(CMD_PART, 0, 1023, 0, 1), 1, order_err);
		add_row(mk_beat(CMD_PART, 777, 600, 300, 300), 0, ok_zero);
		add_row(mk_beat(CMD_UNUSED, 0, 0, 0, 0), 1, range_err);
		add_row(mk_beat(CMD_UNUSED, (1 << IDX_W) - 1, 1023, 1023, 1023), 1, range_err);

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_beat(directed_rows[i].beat, directed_rows[i].known
				? directed_rows[i].want : convert_triple(directed_rows[i].beat));

		// Random part, with stretches of back-to-back beats
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			if (n % 100 == 0)
				burst_mode = ($urandom_range(0, 2) == 0);
			beat = random_beat();
			send_beat(beat, convert_triple(beat));
		end
		start = 0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d beats (index %0d, subset %0d, partition %0d, unused %0d).",
			beats_by_cmd[0] + beats_by_cmd[1] + beats_by_cmd[2] + beats_by_cmd[3],
			beats_by_cmd[0], beats_by_cmd[1], beats_by_cmd[2], beats_by_cmd[3]);
		$display("Checked %0d results: %0d ok, %0d order errors, %0d range errors.",
			results_seen, results_by_status[0], results_by_status[1],
			results_by_status[2]);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
